/* rtl/core/smr_pkg.sv */
// Shared types and constants for the system management responder.
package smr_pkg;

  localparam logic [1:0] REQ_MESSAGE  = 2'd0;
  localparam logic [1:0] REQ_TICK     = 2'd1;
  localparam logic [1:0] REQ_POWER_ON = 2'd2;

  localparam logic [3:0] FC_BOARD_ID1 = 4'd0;
  localparam logic [3:0] FC_BOARD_ID2 = 4'd1;
  localparam logic [3:0] FC_POWER     = 4'd2;
  localparam logic [3:0] FC_POLL      = 4'd3;

  localparam logic [1:0] RF_BOARD_ID1 = 2'd0;
  localparam logic [1:0] RF_BOARD_ID2 = 2'd1;
  localparam logic [1:0] RF_POWER     = 2'd2;
  localparam logic [1:0] RF_POLL      = 2'd3;

  localparam logic [3:0] PRIO_TICK     = 4'hE;
  localparam logic [3:0] PRIO_POWER_ON = 4'hF;

  localparam logic [3:0] LEN_FW    = 4'd3;
  localparam logic [3:0] LEN_POWER = 4'd8;
  localparam logic [3:0] LEN_POLL  = 4'd1;

  localparam logic [1:0] CFG_FEATURE_BITMAP = 2'd0;
  localparam logic [1:0] CFG_FW_MAJOR       = 2'd1;
  localparam logic [1:0] CFG_FW_MINOR       = 2'd2;
  localparam logic [1:0] CFG_FW_PATCH       = 2'd3;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [3:0]  func_code;
    logic        is_request;
    logic [3:0]  msg_priority;
    logic [3:0]  msg_length;
    logic [7:0]  msg_byte0;
    logic [31:0] tick_number;
    logic [31:0] volt_bytes;
    logic [31:0] curr_bytes;
  } item_t;

  typedef struct packed {
    logic [1:0]  resp_function;
    logic [3:0]  resp_priority;
    logic [3:0]  resp_length;
    logic [63:0] resp_payload;
    logic        resp_last;
  } resp_t;

  typedef struct packed {
    logic [63:0] id1_payload;
    logic [3:0]  id1_length;
    logic [23:0] fw_payload;
  } board_info_t;

  typedef struct packed {
    logic  has_res;
    logic  final_beat;
    logic  set_poll;
    logic  set_last;
    resp_t res;
  } gen_t;

endpackage

/* rtl/core/smr_if.sv */
// Item and response channel interfaces.
interface smr_item_if;
  logic        valid;
  logic        ready;
  logic [1:0]  req_type;
  logic [3:0]  func_code;
  logic        is_request;
  logic [3:0]  msg_priority;
  logic [3:0]  msg_length;
  logic [7:0]  msg_byte0;
  logic [31:0] tick_number;
  logic [31:0] volt_bytes;
  logic [31:0] curr_bytes;

  modport source (output valid, req_type, func_code, is_request, msg_priority, msg_length,
                  msg_byte0, tick_number, volt_bytes, curr_bytes, input ready);
  modport sink (input valid, req_type, func_code, is_request, msg_priority, msg_length,
                msg_byte0, tick_number, volt_bytes, curr_bytes, output ready);
endinterface

interface smr_resp_if;
  logic        valid;
  logic        ready;
  logic [1:0]  resp_function;
  logic [3:0]  resp_priority;
  logic [3:0]  resp_length;
  logic [63:0] resp_payload;
  logic        resp_last;

  modport source (output valid, resp_function, resp_priority, resp_length, resp_payload,
                  resp_last, input ready);
  modport sink (input valid, resp_function, resp_priority, resp_length, resp_payload,
                resp_last, output ready);
endinterface

/* rtl/core/smr_cfg_regs.sv */
// Configuration registers and registered board ID nibble packing.
module smr_cfg_regs import smr_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [15:0] cfg_data_i,
  output board_info_t info_o
);

  logic [15:0] feature_q;
  logic [7:0]  major_q, minor_q, patch_q;
  logic [63:0] id1_payload_q, id1_payload_d;
  logic [3:0]  id1_length_q, id1_length_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      feature_q     <= '0;
      major_q       <= '0;
      minor_q       <= '0;
      patch_q       <= '0;
      id1_payload_q <= '0;
      id1_length_q  <= '0;
    end else begin
      id1_payload_q <= id1_payload_d;
      id1_length_q  <= id1_length_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_FEATURE_BITMAP: feature_q <= cfg_data_i;
          CFG_FW_MAJOR:       major_q   <= cfg_data_i[7:0];
          CFG_FW_MINOR:       minor_q   <= cfg_data_i[7:0];
          CFG_FW_PATCH:       patch_q   <= cfg_data_i[7:0];
          default: ;
        endcase
      end
    end
  end

  // slot k takes the index of the set bit that has exactly k set bits below it
  always_comb begin
    logic [4:0] pre_cnt [16];
    logic [4:0] total;
    for (int i = 0; i < 16; i++) begin
      pre_cnt[i] = 5'($countones(feature_q & ~(16'hFFFF << i)));
    end
    total = 5'($countones(feature_q));
    id1_payload_d = '0;
    for (int k = 0; k < 16; k++) begin
      for (int i = 0; i < 16; i++) begin
        if (feature_q[i] && pre_cnt[i] == 5'(k)) begin
          id1_payload_d[4*k +: 4] = id1_payload_d[4*k +: 4] | 4'(i);
        end
      end
    end
    id1_length_d = 4'((5'(total + 5'd1)) >> 1);
  end

  assign info_o.id1_payload = id1_payload_q;
  assign info_o.id1_length  = id1_length_q;
  assign info_o.fw_payload  = {patch_q, minor_q, major_q};

endmodule

/* rtl/core/smr_resp_gen.sv */
// Response decode for one item beat: result fields and state updates.
module smr_resp_gen import smr_pkg::*; (
  input  item_t       item_i,
  input  logic        beat_i,
  input  board_info_t info_i,
  input  logic [7:0]  poll_i,
  input  logic [31:0] last_tick_i,
  output gen_t        gen_o
);

  logic [31:0] tick_diff;
  logic        tick_due;

  assign tick_diff = item_i.tick_number - last_tick_i;
  assign tick_due  = (poll_i != 8'd0) && (tick_diff >= {24'd0, poll_i});

  always_comb begin
    gen_o = '0;
    gen_o.final_beat = 1'b1;
    gen_o.res.resp_last = 1'b1;
    unique case (item_i.req_type)
      REQ_MESSAGE: begin
        gen_o.res.resp_priority = item_i.msg_priority;
        unique case (item_i.func_code)
          FC_BOARD_ID1: begin
            gen_o.has_res = item_i.is_request;
            gen_o.res.resp_function = RF_BOARD_ID1;
            gen_o.res.resp_length   = info_i.id1_length;
            gen_o.res.resp_payload  = info_i.id1_payload;
          end
          FC_BOARD_ID2: begin
            gen_o.has_res = item_i.is_request;
            gen_o.res.resp_function = RF_BOARD_ID2;
            gen_o.res.resp_length   = LEN_FW;
            gen_o.res.resp_payload  = {40'd0, info_i.fw_payload};
          end
          FC_POWER: begin
            gen_o.has_res = item_i.is_request;
            gen_o.res.resp_function = RF_POWER;
            gen_o.res.resp_length   = LEN_POWER;
            gen_o.res.resp_payload  = {item_i.curr_bytes, item_i.volt_bytes};
          end
          FC_POLL: begin
            gen_o.has_res  = item_i.is_request;
            gen_o.set_poll = !item_i.is_request && (item_i.msg_length != 4'd0);
            gen_o.res.resp_function = RF_POLL;
            gen_o.res.resp_length   = LEN_POLL;
            gen_o.res.resp_payload  = {56'd0, poll_i};
          end
          default: ;
        endcase
      end
      REQ_TICK: begin
        gen_o.has_res  = tick_due;
        gen_o.set_last = tick_due;
        gen_o.res.resp_function = RF_POWER;
        gen_o.res.resp_priority = PRIO_TICK;
        gen_o.res.resp_length   = LEN_POWER;
        gen_o.res.resp_payload  = {item_i.curr_bytes, item_i.volt_bytes};
      end
      REQ_POWER_ON: begin
        gen_o.has_res = 1'b1;
        gen_o.res.resp_priority = PRIO_POWER_ON;
        if (!beat_i) begin
          gen_o.final_beat        = 1'b0;
          gen_o.res.resp_last     = 1'b0;
          gen_o.res.resp_function = RF_BOARD_ID1;
          gen_o.res.resp_length   = info_i.id1_length;
          gen_o.res.resp_payload  = info_i.id1_payload;
        end else begin
          gen_o.res.resp_function = RF_BOARD_ID2;
          gen_o.res.resp_length   = LEN_FW;
          gen_o.res.resp_payload  = {40'd0, info_i.fw_payload};
        end
      end
      default: ;
    endcase
  end

endmodule

/* rtl/core/system_management_responder_core.sv */
// System management responder top level: input register, decode, output register.
// Throughput: one item per cycle unless an output stall holds the input register; a
// power-on announce holds it for both of its results. Output stalls back up through it.
// Reset clears polling interval, last send tick, configuration and all valid flags.
module system_management_responder_core import smr_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [15:0] cfg_data_i,
  smr_item_if.sink    item_i,
  smr_resp_if.source  resp_o
);

  board_info_t info;
  gen_t        gen;
  item_t       item_q, item_d;
  logic        item_vld_q;
  logic        beat_q;
  resp_t       out_q;
  logic        out_vld_q;
  logic [7:0]  poll_q;
  logic [31:0] last_tick_q;
  logic        out_free, advance, item_done, take;

  smr_cfg_regs u_cfg (
    .clk_i,
    .rst_ni,
    .cfg_we_i,
    .cfg_idx_i,
    .cfg_data_i,
    .info_o (info)
  );

  smr_resp_gen u_gen (
    .item_i      (item_q),
    .beat_i      (beat_q),
    .info_i      (info),
    .poll_i      (poll_q),
    .last_tick_i (last_tick_q),
    .gen_o       (gen)
  );

  assign out_free  = !out_vld_q || resp_o.ready;
  assign advance   = item_vld_q && (!gen.has_res || out_free);
  assign item_done = advance && gen.final_beat;
  assign item_i.ready = !item_vld_q || item_done;
  assign take = item_i.valid && item_i.ready;

  assign item_d = '{req_type:     item_i.req_type,
                    func_code:    item_i.func_code,
                    is_request:   item_i.is_request,
                    msg_priority: item_i.msg_priority,
                    msg_length:   item_i.msg_length,
                    msg_byte0:    item_i.msg_byte0,
                    tick_number:  item_i.tick_number,
                    volt_bytes:   item_i.volt_bytes,
                    curr_bytes:   item_i.curr_bytes};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_vld_q  <= 1'b0;
      beat_q      <= 1'b0;
      out_vld_q   <= 1'b0;
      poll_q      <= '0;
      last_tick_q <= '0;
    end else begin
      if (take) begin
        item_vld_q <= 1'b1;
      end else if (item_done) begin
        item_vld_q <= 1'b0;
      end
      if (item_done) begin
        beat_q <= 1'b0;
      end else if (advance) begin
        beat_q <= 1'b1;
      end
      if (advance && gen.has_res) begin
        out_vld_q <= 1'b1;
      end else if (resp_o.ready) begin
        out_vld_q <= 1'b0;
      end
      if (item_done && gen.set_poll) begin
        poll_q <= item_q.msg_byte0;
      end
      if (item_done && gen.set_last) begin
        last_tick_q <= item_q.tick_number;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      item_q <= item_d;
    end
    if (advance && gen.has_res) begin
      out_q <= gen.res;
    end
  end

  assign resp_o.valid         = out_vld_q;
  assign resp_o.resp_function = out_q.resp_function;
  assign resp_o.resp_priority = out_q.resp_priority;
  assign resp_o.resp_length   = out_q.resp_length;
  assign resp_o.resp_payload  = out_q.resp_payload;
  assign resp_o.resp_last     = out_q.resp_last;

  a_beat_only_power_on: assert property (@(posedge clk_i) disable iff (!rst_ni)
    beat_q |-> (item_vld_q && item_q.req_type == REQ_POWER_ON))
    else $error("second beat without power-on item");

  a_not_last_is_id1: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && !out_q.resp_last) |-> (out_q.resp_function == RF_BOARD_ID1))
    else $error("non-final beat is not board ID 1");

  a_poll_change: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (poll_q != $past(poll_q)) |-> $past(item_done && gen.set_poll))
    else $error("poll interval changed without a set message");

  a_last_tick_change: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (last_tick_q != $past(last_tick_q)) |-> $past(advance && gen.set_last))
    else $error("last send tick changed without a tick send");

endmodule
